// ===== src/qtir_pkg.sv =====
// ----------------------------------------------------------------------------
// qtir_pkg: shared definitions for the quarter-turn image rotator
// Field widths, status and register codes, reset values and the
// configuration bundle that the front end reads.
// ----------------------------------------------------------------------------
package qtir_pkg;

   // Default frame store geometry.
   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;

   // Fixed field widths.
   localparam int COORD_W    = 6;
   localparam int DIM_W      = 7;
   localparam int PIXEL_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int ROT_W      = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Result status codes. The front end uses the same codes to tell the
   // back end what to do with a command.
   localparam logic [STATUS_W-1:0] STATUS_STORED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_READ_OK = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

   // Item modes.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // Rotation codes in quarter turns.
   localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
   localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
   localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
   localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

   // Register indexes (byte address bits [3:2]).
   localparam logic [1:0] REG_ROTATION      = 2'd0;
   localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd1;
   localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd2;

   // Register reset values.
   localparam logic [ROT_W-1:0] ROTATION_RESET      = ROT_0;
   localparam logic [DIM_W-1:0] SOURCE_WIDTH_RESET  = 7'd64;
   localparam logic [DIM_W-1:0] SOURCE_HEIGHT_RESET = 7'd64;

   typedef struct packed {
      logic [ROT_W-1:0] rotation;
      logic [DIM_W-1:0] source_width;
      logic [DIM_W-1:0] source_height;
   } qtir_cfg_type;

endpackage

// ===== src/qtir_ram.sv =====
// ----------------------------------------------------------------------------
// qtir_ram: generic single-port RAM
// One address per cycle, write or read, with a registered read port.
// ----------------------------------------------------------------------------
module qtir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                           wr_data,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/qtir_front.sv =====
// ----------------------------------------------------------------------------
// qtir_front: item classification and address mapping
// Checks the coordinates against the source or destination bounds and
// maps a destination read back to its source pixel address.
// ----------------------------------------------------------------------------
module qtir_front
   import qtir_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int ADDR_W     = 12
) (
   input  qtir_cfg_type        cfg,
   input  logic                mode,
   input  logic [COORD_W-1:0]  coord_x,
   input  logic [COORD_W-1:0]  coord_y,
   output logic [STATUS_W-1:0] cmd_status,
   output logic [ADDR_W-1:0]   cmd_addr
);

   logic [DIM_W-1:0] w, h, dw, dh, cx, cy, sx, sy, sel_x, sel_y;
   logic             in_src, in_dst;

   always_comb begin
      // Register values above the store geometry saturate to it.
      w = (32'(cfg.source_width) > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg.source_width;
      h = (32'(cfg.source_height) > 32'(MAX_HEIGHT)) ?
          DIM_W'(MAX_HEIGHT) : cfg.source_height;
      cx = DIM_W'(coord_x);
      cy = DIM_W'(coord_y);

      // Odd quarter turns swap the destination dimensions.
      dw = cfg.rotation[0] ? h : w;
      dh = cfg.rotation[0] ? w : h;

      in_src = (cx < w) && (cy < h);
      in_dst = (cx < dw) && (cy < dh);

      unique case (cfg.rotation)
         ROT_90: begin
            sx = cy;
            sy = h - 7'd1 - cx;
         end
         ROT_180: begin
            sx = w - 7'd1 - cx;
            sy = h - 7'd1 - cy;
         end
         ROT_270: begin
            sx = w - 7'd1 - cy;
            sy = cx;
         end
         default: begin
            sx = cx;
            sy = cy;
         end
      endcase

      if (mode == MODE_WRITE) begin
         sel_x      = cx;
         sel_y      = cy;
         cmd_status = in_src ? STATUS_STORED : STATUS_RANGE;
      end else begin
         sel_x      = sx;
         sel_y      = sy;
         cmd_status = in_dst ? STATUS_READ_OK : STATUS_RANGE;
      end

      cmd_addr = ADDR_W'(32'(sel_y) * 32'(MAX_WIDTH) + 32'(sel_x));
   end

endmodule

// ===== src/qtir_queue.sv =====
// ----------------------------------------------------------------------------
// qtir_queue: short command queue
// Decouples the classifying front end from the frame store back end.
// ----------------------------------------------------------------------------
module qtir_queue
   import qtir_pkg::*;
#(
   parameter int WIDTH = 46
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (32'(count_ff) == QUEUE_DEPTH);
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

endmodule

// ===== src/qtir_back.sv =====
// ----------------------------------------------------------------------------
// qtir_back: frame store access and result register
// Executes queued commands against the frame store and holds the result
// word until the downstream side takes it.
// ----------------------------------------------------------------------------
module qtir_back
   import qtir_pkg::*;
#(
   parameter int DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
   parameter int ADDR_W = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  logic [STATUS_W-1:0] cmd_status,
   input  logic [ADDR_W-1:0]   cmd_addr,
   input  logic [PIXEL_W-1:0]  cmd_pixel,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PIXEL_W-1:0]  rsp_pixel_out
);

   logic                inflight_ff, inflight_in;
   logic [STATUS_W-1:0] inflight_status_ff, inflight_status_in;
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [PIXEL_W-1:0]  out_pixel_ff, out_pixel_in;
   logic                out_load, ram_wr, ram_rd;
   logic [PIXEL_W-1:0]  ram_rd_data;

   qtir_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .rd_en   (ram_rd),
      .addr    (cmd_addr),
      .wr_data (cmd_pixel),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      out_load = inflight_ff && (!out_valid_ff || !rsp_stall);
      cmd_pop  = cmd_valid && (!inflight_ff || out_load);
      ram_wr   = cmd_pop && (cmd_status == STATUS_STORED);
      ram_rd   = cmd_pop && (cmd_status == STATUS_READ_OK);

      inflight_in        = cmd_pop ? 1'b1 : (out_load ? 1'b0 : inflight_ff);
      inflight_status_in = cmd_pop ? cmd_status : inflight_status_ff;

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      out_status_in = out_load ? inflight_status_ff : out_status_ff;
      if (out_load) begin
         out_pixel_in = (inflight_status_ff == STATUS_READ_OK) ? ram_rd_data : '0;
      end else begin
         out_pixel_in = out_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         inflight_ff  <= inflight_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inflight_status_ff <= inflight_status_in;
      out_status_ff      <= out_status_in;
      out_pixel_ff       <= out_pixel_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_pixel_out = out_pixel_ff;

   // A command waiting on a blocked result register must not be dropped.
   a_inflight_holds: assert property (@(posedge clock) disable iff (reset)
      inflight_ff && out_valid_ff && rsp_stall |=>
         inflight_ff && $stable(inflight_status_ff))
      else $error("in-flight command lost while result register blocked");

   // A frame store read is always followed by a read-valid command in flight.
   a_read_tracked: assert property (@(posedge clock) disable iff (reset)
      ram_rd |=> inflight_ff && (inflight_status_ff == STATUS_READ_OK))
      else $error("frame store read without matching in-flight command");

endmodule

// ===== src/quarter_turn_image_rotator.sv =====
// ----------------------------------------------------------------------------
// quarter_turn_image_rotator: frame store with rotated readout
// A result word reaches rsp_valid through the queue, then the frame store access,
// then the result register, after the edge that accepts the request word.
// Throughput: one word per cycle while not stalled, set by the single frame store port.
// Reset: synchronous and active high; it clears the queue, the result
// register and the registers to rotation 0 and a 64 by 64 source. The frame
// store is not cleared; its entries hold whatever was last written.
// ----------------------------------------------------------------------------
module quarter_turn_image_rotator
   import qtir_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [COORD_W-1:0]    req_coord_x,
   input  logic [COORD_W-1:0]    req_coord_y,
   input  logic [PIXEL_W-1:0]    req_pixel_in,
   // Response channel.
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [PIXEL_W-1:0]    rsp_pixel_out,
   // Register port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // The frame store holds one word per source pixel, row-major with a row
   // pitch of MAX_WIDTH.
   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QWORD_W = STATUS_W + ADDR_W + PIXEL_W;

   // Configuration registers. Software only writes them while the block is idle; the
   // block itself does not enforce this, and the front end reads them directly without any shadowing.
   logic [ROT_W-1:0] rotation_ff, rotation_in;
   logic [DIM_W-1:0] source_width_ff, source_width_in;
   logic [DIM_W-1:0] source_height_ff, source_height_in;
   logic             csr_write;
   qtir_cfg_type     cfg;

   always_comb begin
      csr_write        = csr_psel && csr_penable && csr_pwrite;
      rotation_in      = rotation_ff;
      source_width_in  = source_width_ff;
      source_height_in = source_height_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_ROTATION:      rotation_in      = csr_pwdata[ROT_W-1:0];
            REG_SOURCE_WIDTH:  source_width_in  = csr_pwdata[DIM_W-1:0];
            REG_SOURCE_HEIGHT: source_height_in = csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff      <= ROTATION_RESET;
         source_width_ff  <= SOURCE_WIDTH_RESET;
         source_height_ff <= SOURCE_HEIGHT_RESET;
      end else begin
         rotation_ff      <= rotation_in;
         source_width_ff  <= source_width_in;
         source_height_ff <= source_height_in;
      end
   end

   // Reads return the register value; the unused slot reads as zero.
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_ROTATION:      csr_prdata = CSR_DATA_W'(rotation_ff);
         REG_SOURCE_WIDTH:  csr_prdata = CSR_DATA_W'(source_width_ff);
         REG_SOURCE_HEIGHT: csr_prdata = CSR_DATA_W'(source_height_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   assign cfg.rotation      = rotation_ff;
   assign cfg.source_width  = source_width_ff;
   assign cfg.source_height = source_height_ff;

   // Front end: classify each request word and compute its store address.
   logic [STATUS_W-1:0] front_status;
   logic [ADDR_W-1:0]   front_addr;

   qtir_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .cfg        (cfg),
      .mode       (req_mode),
      .coord_x    (req_coord_x),
      .coord_y    (req_coord_y),
      .cmd_status (front_status),
      .cmd_addr   (front_addr)
   );

   // Command queue. The request side is stalled only when it is full, so
   // the front end keeps accepting while the back end waits on the output.
   logic               q_full, q_not_empty, q_pop, q_push;
   logic [QWORD_W-1:0] q_push_data, q_pop_data;

   assign q_push      = req_valid && !q_full;
   assign q_push_data = {front_status, front_addr, req_pixel_in};
   assign req_stall   = q_full;

   qtir_queue #(
      .WIDTH (QWORD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_pop_data)
   );

   // Back end: frame store access and the result register.
   qtir_back #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (q_not_empty),
      .cmd_status    (q_pop_data[QWORD_W-1 -: STATUS_W]),
      .cmd_addr      (q_pop_data[PIXEL_W +: ADDR_W]),
      .cmd_pixel     (q_pop_data[PIXEL_W-1:0]),
      .cmd_pop       (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_pixel_out (rsp_pixel_out)
   );

   // Only a successful read carries pixel data.
   a_zero_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_READ_OK) |-> (rsp_pixel_out == '0))
      else $error("nonzero pixel on a result that is not a read");

   // The result status is one of the three defined codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_STORED) || (rsp_status == STATUS_READ_OK) ||
                    (rsp_status == STATUS_RANGE))
      else $error("undefined result status");

   // Reset leaves both channels idle and ready.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("channels not idle after reset");

   // A rotation write lands in the register on the next cycle.
   a_rotation_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && (csr_paddr[3:2] == REG_ROTATION) |=>
         (rotation_ff == $past(csr_pwdata[ROT_W-1:0])))
      else $error("rotation register write lost");

endmodule
